// ===== hdl/ptc_pkg.sv =====
// Shared constants for the pressure and temperature compensation block.
`default_nettype none

package ptc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int PRES_W    = 29;
    localparam int TEMP_W    = 13;
    localparam int CFG_IDX_W = 3;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS_AT_REF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_AT_REF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE       = 3'd5;

    // Temperature in centidegrees: 20 C reference, -15 C cold limit
    localparam logic signed [19:0] TEMP_REF    = 20'sd2000;
    localparam logic signed [18:0] COLD_MARGIN = 19'sd3500;

    // Reciprocal constants for unsigned 32-bit divide by 10 and by 100
    localparam logic [31:0] DIV10_MAGIC  = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;
    localparam logic [30:0] DIV100_MAGIC = 31'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

endpackage

`default_nettype wire

// ===== hdl/pressure_temp_compensation_unit.sv =====
// Pipelined second-order pressure and temperature compensation.
//
// Usage:
//   Write the six 16-bit calibration coefficients through cfg_write,
//   cfg_index and cfg_data while no beat is in flight; a write with an
//   index past the last register is dropped. Present a raw pressure and
//   raw temperature conversion with start; busy stays low, so a beat is
//   taken on every cycle that start is high. Each beat comes back on
//   pressure_mbar and temperature_c, marked by done for one cycle, in
//   order. The sustained rate is one beat per cycle: twelve register
//   stages, with the 40x24-bit pressure product split into two partial
//   products and both final divides done by reciprocal multiplication.
//   Results cannot be held off by the receiver; the pipeline never
//   stalls. Reset clears all calibration registers to zero and empties
//   the pipeline, so no done appears until new beats arrive.
`default_nettype none

module pressure_temp_compensation_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [ptc_pkg::RAW_W-1:0]             raw_pressure,
    input  wire logic [ptc_pkg::RAW_W-1:0]             raw_temperature,
    output logic                                       done,
    output logic signed [ptc_pkg::PRES_W-1:0]          pressure_mbar,
    output logic signed [ptc_pkg::TEMP_W-1:0]          temperature_c,
    input  wire logic                                  cfg_write,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ptc_pkg::COEF_W-1:0]            cfg_data
);

    localparam int PIPE_DEPTH = 12;

    // Calibration registers
    logic [15:0] sens_at_ref_reg;
    logic [15:0] offset_at_ref_reg;
    logic [15:0] sens_temp_coef_reg;
    logic [15:0] offset_temp_coef_reg;
    logic [15:0] ref_temperature_reg;
    logic [15:0] temp_slope_reg;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  accept;

    // Stage 1
    logic signed [24:0] dt_next;
    logic signed [24:0] s1_dt_reg;
    logic [23:0]        s1_d1_reg;

    // Stage 2
    logic signed [49:0] dtsq_full;
    logic signed [41:0] s2_slope_prod_reg;
    logic [47:0]        s2_dtsq_reg;
    logic signed [41:0] s2_off_prod_reg;
    logic signed [41:0] s2_sens_prod_reg;
    logic [23:0]        s2_d1_reg;

    // Stage 3
    logic signed [17:0] dev_next;
    logic               cold_next;
    logic [49:0]        dtsq3;
    logic [16:0]        t2_next;
    logic signed [34:0] off_adj;
    logic signed [33:0] sens_adj;
    logic signed [35:0] off1_next;
    logic signed [34:0] sens1_next;
    logic signed [17:0] s3_dev_reg;
    logic               s3_cold_reg;
    logic [16:0]        s3_t2_reg;
    logic signed [35:0] s3_off1_reg;
    logic signed [34:0] s3_sens1_reg;
    logic [23:0]        s3_d1_reg;

    // Stage 4
    logic signed [18:0] low_next;
    logic signed [35:0] dd_full;
    logic signed [37:0] ll_full;
    logic signed [19:0] tdiff_next;
    logic [34:0]        s4_dd_reg;
    logic [34:0]        s4_ll_reg;
    logic               s4_cold_reg;
    logic               s4_frigid_reg;
    logic signed [19:0] s4_tdiff_reg;
    logic signed [35:0] s4_off1_reg;
    logic signed [34:0] s4_sens1_reg;
    logic [23:0]        s4_d1_reg;

    // Stage 5
    logic [35:0]        dd3;
    logic [37:0]        ll7;
    logic [36:0]        dd5;
    logic [36:0]        ll4;
    logic [37:0]        off2_next;
    logic [37:0]        sens2_next;
    logic signed [19:0] tdiff_neg;
    logic [17:0]        tmag_next;
    logic [37:0]        s5_off2_reg;
    logic [37:0]        s5_sens2_reg;
    logic               s5_tneg_reg;
    logic [17:0]        s5_tmag_reg;
    logic signed [35:0] s5_off1_reg;
    logic signed [34:0] s5_sens1_reg;
    logic [23:0]        s5_d1_reg;

    // Stage 6
    logic signed [39:0] s6_off_reg;
    logic signed [39:0] s6_sens_reg;
    logic [48:0]        s6_tprod_reg;
    logic               s6_tneg_reg;
    logic [23:0]        s6_d1_reg;

    // Stage 7
    logic [11:0]        tq;
    logic [43:0]        s7_pp_lo_reg;
    logic signed [44:0] s7_pp_hi_reg;
    logic signed [39:0] s7_off_reg;
    logic signed [12:0] s7_tres_reg;

    // Stage 8
    logic signed [63:0] s8_prod_reg;
    logic signed [39:0] s8_off_reg;
    logic signed [12:0] s8_tres_reg;

    // Stage 9
    logic signed [43:0] press_raw;
    logic signed [31:0] s9_p_reg;
    logic signed [12:0] s9_tres_reg;

    // Stage 10
    logic [31:0]        s10_pmag_reg;
    logic               s10_pneg_reg;
    logic signed [12:0] s10_tres_reg;

    // Stage 11
    logic [63:0]        s11_pprod_reg;
    logic               s11_pneg_reg;
    logic signed [12:0] s11_tres_reg;

    // Output stage
    logic [28:0]        pq;
    logic signed [28:0] pressure_mbar_reg;
    logic signed [12:0] temperature_c_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_at_ref_reg      <= '0;
            offset_at_ref_reg    <= '0;
            sens_temp_coef_reg   <= '0;
            offset_temp_coef_reg <= '0;
            ref_temperature_reg  <= '0;
            temp_slope_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_SENS_AT_REF:      sens_at_ref_reg      <= cfg_data;
                ptc_pkg::REG_OFFSET_AT_REF:    offset_at_ref_reg    <= cfg_data;
                ptc_pkg::REG_SENS_TEMP_COEF:   sens_temp_coef_reg   <= cfg_data;
                ptc_pkg::REG_OFFSET_TEMP_COEF: offset_temp_coef_reg <= cfg_data;
                ptc_pkg::REG_REF_TEMPERATURE:  ref_temperature_reg  <= cfg_data;
                ptc_pkg::REG_TEMP_SLOPE:       temp_slope_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Valid bits advance one stage per cycle alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // ---- Combinational logic between stages ----

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temperature_reg, 8'd0});

    assign dtsq_full = s1_dt_reg * s1_dt_reg;

    // dev = TEMP - 2000; below 20 C exactly when dev is negative
    assign dev_next  = s2_slope_prod_reg[40:23];
    assign cold_next = s2_slope_prod_reg[41];
    assign dtsq3     = {2'd0, s2_dtsq_reg} + {1'b0, s2_dtsq_reg, 1'b0};
    assign t2_next   = cold_next ? dtsq3[49:33] : {5'd0, s2_dtsq_reg[47:36]};
    assign off_adj   = s2_off_prod_reg[41:7];
    assign sens_adj  = s2_sens_prod_reg[41:8];
    assign off1_next = $signed({4'd0, offset_at_ref_reg, 16'd0})
                     + $signed({off_adj[34], off_adj});
    assign sens1_next = $signed({4'd0, sens_at_ref_reg, 15'd0})
                      + $signed({sens_adj[33], sens_adj});

    // low = TEMP + 1500
    assign low_next   = $signed({s3_dev_reg[17], s3_dev_reg}) + ptc_pkg::COLD_MARGIN;
    assign dd_full    = s3_dev_reg * s3_dev_reg;
    assign ll_full    = low_next * low_next;
    assign tdiff_next = $signed({{2{s3_dev_reg[17]}}, s3_dev_reg}) + ptc_pkg::TEMP_REF
                      - $signed({3'd0, s3_t2_reg});

    assign dd3 = {1'b0, s4_dd_reg} + {s4_dd_reg, 1'b0};
    assign ll7 = {s4_ll_reg, 3'd0} - {3'd0, s4_ll_reg};
    assign dd5 = {s4_dd_reg, 2'd0} + {2'd0, s4_dd_reg};
    assign ll4 = {s4_ll_reg, 2'd0};

    always_comb
    begin
        if (s4_cold_reg)
        begin
            off2_next  = {3'd0, dd3[35:1]} + (s4_frigid_reg ? ll7 : 38'd0);
            sens2_next = {4'd0, dd5[36:3]} + (s4_frigid_reg ? {1'b0, ll4} : 38'd0);
        end
        else
        begin
            off2_next  = {7'd0, s4_dd_reg[34:4]};
            sens2_next = '0;
        end
    end

    assign tdiff_neg = -s4_tdiff_reg;
    assign tmag_next = s4_tdiff_reg[19] ? tdiff_neg[17:0] : s4_tdiff_reg[17:0];

    assign tq = s6_tprod_reg[48:ptc_pkg::DIV100_SHIFT];

    assign press_raw = $signed({s8_prod_reg[63], s8_prod_reg[63:21]})
                     - $signed({{4{s8_off_reg[39]}}, s8_off_reg});

    assign pq = s11_pprod_reg[63:ptc_pkg::DIV10_SHIFT];

    // ---- Pipeline registers ----
    always_ff @(posedge clk)
    begin
        // stage 1: temperature difference
        s1_dt_reg <= dt_next;
        s1_d1_reg <= raw_pressure;

        // stage 2: products of dT
        s2_slope_prod_reg <= s1_dt_reg * $signed({1'b0, temp_slope_reg});
        s2_dtsq_reg       <= dtsq_full[47:0];
        s2_off_prod_reg   <= s1_dt_reg * $signed({1'b0, offset_temp_coef_reg});
        s2_sens_prod_reg  <= s1_dt_reg * $signed({1'b0, sens_temp_coef_reg});
        s2_d1_reg         <= s1_d1_reg;

        // stage 3: first-order terms and T2
        s3_dev_reg   <= dev_next;
        s3_cold_reg  <= cold_next;
        s3_t2_reg    <= t2_next;
        s3_off1_reg  <= off1_next;
        s3_sens1_reg <= sens1_next;
        s3_d1_reg    <= s2_d1_reg;

        // stage 4: squares
        s4_dd_reg     <= dd_full[34:0];
        s4_ll_reg     <= ll_full[34:0];
        s4_cold_reg   <= s3_cold_reg;
        s4_frigid_reg <= low_next[18];
        s4_tdiff_reg  <= tdiff_next;
        s4_off1_reg   <= s3_off1_reg;
        s4_sens1_reg  <= s3_sens1_reg;
        s4_d1_reg     <= s3_d1_reg;

        // stage 5: second-order corrections
        s5_off2_reg  <= off2_next;
        s5_sens2_reg <= sens2_next;
        s5_tneg_reg  <= s4_tdiff_reg[19];
        s5_tmag_reg  <= tmag_next;
        s5_off1_reg  <= s4_off1_reg;
        s5_sens1_reg <= s4_sens1_reg;
        s5_d1_reg    <= s4_d1_reg;

        // stage 6: OFF, SENS and temperature reciprocal product
        s6_off_reg   <= $signed({{4{s5_off1_reg[35]}}, s5_off1_reg})
                      - $signed({2'd0, s5_off2_reg});
        s6_sens_reg  <= $signed({{5{s5_sens1_reg[34]}}, s5_sens1_reg})
                      - $signed({2'd0, s5_sens2_reg});
        s6_tprod_reg <= 49'(s5_tmag_reg) * 49'(ptc_pkg::DIV100_MAGIC);
        s6_tneg_reg  <= s5_tneg_reg;
        s6_d1_reg    <= s5_d1_reg;

        // stage 7: split D1*SENS into two partial products
        s7_pp_lo_reg <= 44'(s6_d1_reg) * 44'(s6_sens_reg[19:0]);
        s7_pp_hi_reg <= $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[39:20]);
        s7_off_reg   <= s6_off_reg;
        s7_tres_reg  <= s6_tneg_reg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

        // stage 8: recombine partial products
        s8_prod_reg <= $signed({s7_pp_hi_reg[43:0], 20'd0}) + $signed({20'd0, s7_pp_lo_reg});
        s8_off_reg  <= s7_off_reg;
        s8_tres_reg <= s7_tres_reg;

        // stage 9: scale and subtract offset
        s9_p_reg    <= $signed({press_raw[43], press_raw[43:13]});
        s9_tres_reg <= s8_tres_reg;

        // stage 10: magnitude for truncating divide
        s10_pneg_reg <= s9_p_reg[31];
        s10_pmag_reg <= s9_p_reg[31] ? 32'(-s9_p_reg) : 32'(s9_p_reg);
        s10_tres_reg <= s9_tres_reg;

        // stage 11: reciprocal product for divide by 10
        s11_pprod_reg <= 64'(s10_pmag_reg) * 64'(ptc_pkg::DIV10_MAGIC);
        s11_pneg_reg  <= s10_pneg_reg;
        s11_tres_reg  <= s10_tres_reg;

        // output stage: restore sign
        pressure_mbar_reg <= s11_pneg_reg ? -$signed(pq) : $signed(pq);
        temperature_c_reg <= s11_tres_reg;
    end

    assign done          = vld_reg[PIPE_DEPTH-1];
    assign pressure_mbar = pressure_mbar_reg;
    assign temperature_c = temperature_c_reg;

    // ---- Assertions ----
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("accepted beat did not produce done");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_DEPTH))
        else $error("done without a matching accepted beat");

    a_temp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (temperature_c >= -13'sd2300) && (temperature_c <= 13'sd2300))
        else $error("temperature result out of reachable range");

    a_pmag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[9] |-> (s10_pmag_reg <= 32'h8000_0000))
        else $error("pressure magnitude exceeds 32-bit signed range");

endmodule

`default_nettype wire
